// ===== src/utf8d_pkg.sv =====
// Shared constants, types and helper functions for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [20:0] CpRawBase   = 21'h110000;
  localparam logic [20:0] CpMin2      = 21'h000080;
  localparam logic [20:0] CpMin3      = 21'h000800;
  localparam logic [20:0] CpSurrLo    = 21'h00D800;
  localparam logic [20:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [20:0] CpMin4      = 21'h010000;
  localparam logic [20:0] CpMax       = 21'h10FFFF;

  localparam logic [7:0] MaskLead2 = 8'hE0;
  localparam logic [7:0] CodeLead2 = 8'hC0;
  localparam logic [7:0] MaskLead3 = 8'hF0;
  localparam logic [7:0] CodeLead3 = 8'hE0;
  localparam logic [7:0] MaskLead4 = 8'hF8;
  localparam logic [7:0] CodeLead4 = 8'hF0;
  localparam logic [1:0] ContTag   = 2'b10;

  // Sequence length code: 1 means not a lead byte
  typedef logic [2:0] seq_len_t;

  // One decoded result
  typedef struct packed {
    logic [20:0] cp;
    logic        raw;
  } res_t;

  // Length of the sequence that a lead byte opens
  function automatic seq_len_t seq_len(input logic [7:0] lead);
    seq_len_t len;
    if ((lead & MaskLead2) == CodeLead2) begin
      len = 3'd2;
    end else if ((lead & MaskLead3) == CodeLead3) begin
      len = 3'd3;
    end else if ((lead & MaskLead4) == CodeLead4) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Raw escape of a byte: 0x110000 plus the byte
  function automatic res_t raw_res(input logic [7:0] b);
    res_t r;
    r.cp  = CpRawBase | {13'd0, b};
    r.raw = 1'b1;
    return r;
  endfunction

endpackage

// ===== src/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder: one byte per request in, code points or raw escapes out.
// A result appears on the master side in the cycle after its byte is accepted.
// One byte per cycle while each byte yields at most one result and the master side
// takes it; a byte that yields more results (up to four) holds intake until only its
// last result waits and is taken. Reset (rst, synchronous) empties the queue and drops
// any pending sequence.
module utf8_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [21] run_last, [23:22] zero
  output logic        m_tuser,   // is_raw
  output logic        m_tlast    // stream_end
);

  // Decoder state
  logic [1:0] pc, pc_next;
  logic [7:0] lead, lead_next;
  logic [7:0] c0, c0_next;
  logic [7:0] c1, c1_next;

  // Result queue (slot 0 is the head)
  utf8d_pkg::res_t q [utf8d_pkg::MaxResults];
  logic [2:0]      rem;
  logic            q_end;

  // Result list built for the byte at the input
  utf8d_pkg::res_t lst [utf8d_pkg::MaxResults];
  logic [2:0]      n;

  logic accept, pop;
  logic do_flush, do_fresh, do_complete;
  utf8d_pkg::seq_len_t lead_len;
  logic [20:0] val;
  logic        val_ok;

  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (rem != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (rem == 3'd0) || ((rem == 3'd1) && m_tready);

  // Assemble the scalar of a completing sequence and range-check it
  always_comb begin
    lead_len = utf8d_pkg::seq_len(lead);
    case (lead_len)
      3'd2: begin
        val    = {10'd0, lead[4:0], s_tdata[5:0]};
        val_ok = (val >= utf8d_pkg::CpMin2);
      end
      3'd3: begin
        val    = {5'd0, lead[3:0], c0[5:0], s_tdata[5:0]};
        val_ok = (val >= utf8d_pkg::CpMin3) &&
                 !((val >= utf8d_pkg::CpSurrLo) && (val <= utf8d_pkg::CpSurrHi));
      end
      default: begin
        val    = {lead[2:0], c0[5:0], c1[5:0], s_tdata[5:0]};
        val_ok = (val >= utf8d_pkg::CpMin4) && (val <= utf8d_pkg::CpMax);
      end
    endcase
  end

  // Decode one byte into a list of results and the next state
  always_comb begin
    pc_next   = pc;
    lead_next = lead;
    c0_next   = c0;
    c1_next   = c1;
    n         = 3'd0;
    for (int i = 0; i < utf8d_pkg::MaxResults; i++) begin
      lst[i] = '0;
    end
    do_flush    = 1'b0;
    do_fresh    = 1'b0;
    do_complete = 1'b0;

    // Classify against the pending sequence
    if (pc == 2'd0) begin
      do_fresh = 1'b1;
    end else if (s_tdata[7:6] != utf8d_pkg::ContTag) begin
      do_flush = 1'b1;
      do_fresh = 1'b1;
    end else if (({1'b0, pc} + 3'd1) >= lead_len) begin
      do_complete = 1'b1;
      if (!val_ok) begin
        do_flush = 1'b1;
      end
    end else begin
      if (pc == 2'd1) begin
        c0_next = s_tdata;
      end else begin
        c1_next = s_tdata;
      end
      pc_next = pc + 2'd1;
    end

    // Drop the pending sequence as raw bytes
    if (do_flush) begin
      lst[n[1:0]] = utf8d_pkg::raw_res(lead);
      n = n + 3'd1;
      if (pc >= 2'd2) begin
        lst[n[1:0]] = utf8d_pkg::raw_res(c0);
        n = n + 3'd1;
      end
      if (pc == 2'd3) begin
        lst[n[1:0]] = utf8d_pkg::raw_res(c1);
        n = n + 3'd1;
      end
      pc_next = 2'd0;
    end

    // Finish a sequence: scalar, or the last byte raw after the flush
    if (do_complete) begin
      if (val_ok) begin
        lst[n[1:0]].cp  = val;
        lst[n[1:0]].raw = 1'b0;
      end else begin
        lst[n[1:0]] = utf8d_pkg::raw_res(s_tdata);
      end
      n = n + 3'd1;
      pc_next = 2'd0;
    end

    // Handle the byte with nothing pending
    if (do_fresh) begin
      if (s_tdata[7] == 1'b0) begin
        lst[n[1:0]].cp  = {13'd0, s_tdata};
        lst[n[1:0]].raw = 1'b0;
        n = n + 3'd1;
      end else if (utf8d_pkg::seq_len(s_tdata) > 3'd1) begin
        lead_next = s_tdata;
        pc_next   = 2'd1;
      end else begin
        lst[n[1:0]] = utf8d_pkg::raw_res(s_tdata);
        n = n + 3'd1;
      end
    end

    // Truncation at the end of the buffer
    if (s_tlast && (pc_next != 2'd0)) begin
      lst[n[1:0]] = utf8d_pkg::raw_res(lead_next);
      n = n + 3'd1;
      if (pc_next >= 2'd2) begin
        lst[n[1:0]] = utf8d_pkg::raw_res(c0_next);
        n = n + 3'd1;
      end
      if (pc_next == 2'd3) begin
        lst[n[1:0]] = utf8d_pkg::raw_res(c1_next);
        n = n + 3'd1;
      end
      pc_next = 2'd0;
    end
  end

  // Advance decoder state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 2'd0;
      lead <= 8'd0;
    end else if (accept) begin
      pc   <= pc_next;
      lead <= lead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c0 <= c0_next;
      c1 <= c1_next;
    end
  end

  // Queue count: load a new list, or drop the head once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (accept) begin
      rem <= n;
    end else if (pop) begin
      rem <= rem - 3'd1;
    end
  end

  // Queue payload: load or shift toward the head
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < utf8d_pkg::MaxResults; i++) begin
        q[i] <= lst[i];
      end
      q_end <= s_tlast;
    end else if (pop) begin
      for (int i = 0; i < utf8d_pkg::MaxResults - 1; i++) begin
        q[i] <= q[i + 1];
      end
    end
  end

  assign m_tdata = {2'b00, (rem == 3'd1), q[0].cp};
  assign m_tuser = q[0].raw;
  assign m_tlast = (rem == 3'd1) && q_end;

  // Intake stays closed while more than one result waits
  assert property (@(posedge clk) disable iff (rst) (rem > 3'd1) |-> !s_tready)
    else $error("input taken while result queue still busy");

  // A raw result always carries 0x110000 plus a byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[20:8] == 13'h1100))
    else $error("raw result outside escape range");

  // A decoded scalar is never a surrogate or above the Unicode range
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata[20:0] <= utf8d_pkg::CpMax) &&
      !((m_tdata[20:0] >= utf8d_pkg::CpSurrLo) && (m_tdata[20:0] <= utf8d_pkg::CpSurrHi))))
    else $error("decoded scalar out of range");

  // Buffer end is only flagged on the last result of a byte
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tlast) |-> m_tdata[21])
    else $error("stream end without run end");

endmodule

// ===== dv/utf8_stream_decoder_checker.sv =====
// Checker for the UTF-8 stream decoder: predicts results per accepted byte and compares them.
module utf8_stream_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // buffer_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [20:0] code_point, [21] run_last, [23:22] zero
  input  logic        m_tuser,   // is_raw
  input  logic        m_tlast,   // stream_end
  output int          fail_count,
  output int          waiting_count
);

  typedef struct {
    logic [20:0] cp;
    logic        raw;
    logic        run_last;
    logic        stream_end;
  } cp_result_t;

  // Expected code points in arrival order
  cp_result_t cp_expect_q[$];
  // Results of the byte being decoded
  cp_result_t byte_results[$];

  // Decoder state mirror
  logic [7:0] lead_q;
  logic [7:0] cont_q [2];
  logic [1:0] held_n;
  int         errs = 0;

  function automatic int lead_length(input logic [7:0] b);
    casez (b)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic void emit(input logic [20:0] cp, input logic raw);
    cp_result_t r;
    r.cp         = cp;
    r.raw        = raw;
    r.run_last   = 1'b0;
    r.stream_end = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void emit_raw(input logic [7:0] b);
    emit(utf8d_pkg::CpRawBase + {13'd0, b}, 1'b1);
  endfunction

  // Drop the pending sequence, lead and held continuations raw
  function automatic void flush_held();
    if (held_n != 2'd0) begin
      emit_raw(lead_q);
      if (held_n >= 2'd2) emit_raw(cont_q[0]);
      if (held_n >= 2'd3) emit_raw(cont_q[1]);
      held_n = 2'd0;
    end
  endfunction

  function automatic void take_fresh(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      emit({13'd0, b}, 1'b0);
    end else if (lead_length(b) > 1) begin
      lead_q = b;
      held_n = 2'd1;
    end else begin
      emit_raw(b);
    end
  endfunction

  // Close a sequence with its final continuation and range-check the value
  function automatic void finish_seq(input logic [7:0] last);
    logic [20:0] v;
    logic        ok;
    case (lead_length(lead_q))
      2: begin
        v  = {10'd0, lead_q[4:0], last[5:0]};
        ok = (v >= utf8d_pkg::CpMin2);
      end
      3: begin
        v  = {5'd0, lead_q[3:0], cont_q[0][5:0], last[5:0]};
        ok = (v >= utf8d_pkg::CpMin3) &&
             !((v >= utf8d_pkg::CpSurrLo) && (v <= utf8d_pkg::CpSurrHi));
      end
      default: begin
        v  = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], last[5:0]};
        ok = (v >= utf8d_pkg::CpMin4) && (v <= utf8d_pkg::CpMax);
      end
    endcase
    if (ok) begin
      emit(v, 1'b0);
      held_n = 2'd0;
    end else begin
      flush_held();
      emit_raw(last);
    end
  endfunction

  // Work out every result one input byte causes and queue them
  function automatic void decode_byte(input logic [7:0] b, input logic buf_end);
    byte_results.delete();
    if (held_n == 2'd0) begin
      take_fresh(b);
    end else if (b[7:6] != utf8d_pkg::ContTag) begin
      flush_held();
      take_fresh(b);
    end else if (int'(held_n) + 1 >= lead_length(lead_q)) begin
      finish_seq(b);
    end else begin
      cont_q[held_n - 2'd1] = b;
      held_n = held_n + 2'd1;
    end
    if (buf_end) flush_held();
    if (byte_results.size() > 0) begin
      byte_results[byte_results.size() - 1].run_last   = 1'b1;
      byte_results[byte_results.size() - 1].stream_end = buf_end;
    end
    foreach (byte_results[i]) cp_expect_q.push_back(byte_results[i]);
  endfunction

  function automatic void compare_field(input string what, input logic [20:0] want,
                                        input logic [20:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errs++;
    end
  endfunction

  // Predict on each byte request, compare on each result request
  always @(posedge clk) begin : watch
    cp_result_t want;
    if (rst) begin
      cp_expect_q.delete();
      held_n = 2'd0;
      lead_q = 8'd0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (cp_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cp %h raw %b",
                   $time, m_tdata[20:0], m_tuser);
          errs++;
        end else begin
          want = cp_expect_q.pop_front();
          compare_field("code_point", want.cp, m_tdata[20:0]);
          compare_field("is_raw", {20'd0, want.raw}, {20'd0, m_tuser});
          compare_field("run_last", {20'd0, want.run_last}, {20'd0, m_tdata[21]});
          compare_field("stream_end", {20'd0, want.stream_end}, {20'd0, m_tlast});
          compare_field("tdata pad", 21'd0, {19'd0, m_tdata[23:22]});
        end
      end
    end
    fail_count    <= errs;
    waiting_count <= cp_expect_q.size();
  end

endmodule

// ===== dv/utf8_stream_decoder_top_test.sv =====
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module utf8_stream_decoder_top_test;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 155;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int         fail_count;
  int         waiting_count;
  int         cycle_count = 0;
  int         sent_bytes  = 0;
  bit         no_idle     = 1'b0;
  logic [7:0] byte_seq[$];

  utf8_stream_decoder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_stream_decoder_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each request
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Send one byte request after a random gap; return at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= b;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
    if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
  endtask

  // Send byte_seq, marking buffer end on index end_at (negative for none)
  task automatic send_seq(input int end_at);
    foreach (byte_seq[i]) send_byte(byte_seq[i], i == end_at);
  endtask

  // Append the well-formed encoding of a scalar of the given length
  function automatic void encode_cp(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        byte_seq.push_back(utf8d_pkg::CodeLead2 | {3'd0, cp[10:6]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[5:0]});
      end
      3: begin
        byte_seq.push_back(utf8d_pkg::CodeLead3 | {4'd0, cp[15:12]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[11:6]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[5:0]});
      end
      default: begin
        byte_seq.push_back(utf8d_pkg::CodeLead4 | {5'd0, cp[20:18]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[17:12]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[11:6]});
        byte_seq.push_back({utf8d_pkg::ContTag, cp[5:0]});
      end
    endcase
  endfunction

  // Draw a valid scalar of the given length, range edges now and then
  function automatic logic [20:0] pick_cp(input int len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    lo = (len == 2) ? utf8d_pkg::CpMin2 : (len == 3) ? utf8d_pkg::CpMin3 : utf8d_pkg::CpMin4;
    hi = (len == 2) ? 21'h0007FF : (len == 3) ? 21'h00FFFF : utf8d_pkg::CpMax;
    case ($urandom_range(0, 9))
      0:       cp = lo;
      1:       cp = hi;
      default: cp = 21'($urandom_range(lo, hi));
    endcase
    if (len == 3 && cp >= utf8d_pkg::CpSurrLo && cp <= utf8d_pkg::CpSurrHi) begin
      cp = utf8d_pkg::CpSurrHi + 21'd1;
    end
    return cp;
  endfunction

  // Build one random sequence: mostly well formed, some damaged, some noise
  task automatic build_random_seq();
    int         kind;
    int         len;
    int         keep;
    logic [7:0] b;
    byte_seq.delete();
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    if (kind < 30) begin
      b = 8'($urandom_range(0, 127));
      byte_seq.push_back(b);
    end else if (kind < 65) begin
      encode_cp(pick_cp(len), len);
    end else if (kind < 80) begin
      // lead and continuations with random payload: overlong, surrogate, too big
      b = 8'($urandom_range(0, 255));
      case (len)
        2:       byte_seq.push_back(utf8d_pkg::CodeLead2 | {3'd0, b[4:0]});
        3:       byte_seq.push_back(utf8d_pkg::CodeLead3 | {4'd0, b[3:0]});
        default: byte_seq.push_back(utf8d_pkg::CodeLead4 | {5'd0, b[2:0]});
      endcase
      repeat (len - 1) begin
        b = 8'($urandom_range(0, 63));
        byte_seq.push_back({utf8d_pkg::ContTag, b[5:0]});
      end
    end else if (kind < 90) begin
      // cut a valid sequence short and break it with a non-continuation
      encode_cp(pick_cp(len), len);
      keep = $urandom_range(1, len - 1);
      while (byte_seq.size() > keep) void'(byte_seq.pop_back());
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == utf8d_pkg::ContTag) b[6] = 1'b1;
      byte_seq.push_back(b);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        byte_seq.push_back(b);
      end
    end
  endtask

  initial begin
    int random_goal;
    int end_at;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: ASCII extremes, strays, two- and four-byte scalars, each error kind
    byte_seq = {8'h00};                      send_seq(-1);
    byte_seq = {8'h7F};                      send_seq(0);
    byte_seq = {8'hBF, 8'hFF, 8'hF8};        send_seq(-1);
    byte_seq = {8'hC3, 8'hA9};               send_seq(-1);
    byte_seq = {8'hC1, 8'hBF};               send_seq(-1);
    byte_seq = {8'hED, 8'hA0, 8'h80};        send_seq(-1);
    byte_seq = {8'hF4, 8'h90, 8'h80, 8'h80}; send_seq(-1);
    byte_seq = {8'hF0, 8'h9F, 8'h98, 8'h80}; send_seq(-1);
    byte_seq = {8'hE2, 8'h82, 8'h41};        send_seq(-1);
    byte_seq = {8'hF1, 8'h80};               send_seq(1);

    // Random sequences, buffer end now and then at any byte
    random_goal = sent_bytes + RandomBytes;
    while (sent_bytes < random_goal) begin
      build_random_seq();
      end_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, byte_seq.size() - 1) : -1;
      send_seq(end_at);
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
